[hdl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg: shared constants and types for the melody tone sequencer
// Field widths, register and command codes, reset values of the registers.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int TEMPO_W   = 16;
    localparam int GAP_W     = 10;
    localparam int COUNT_W   = 9;
    localparam int PITCH_W   = 16;
    localparam int BEATS_W   = 8;
    localparam int INDEX_W   = 8;
    localparam int ELAPSED_W = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int MS_PER_SECOND = 1000;
    localparam int MS_CONST_W    = 10;
    // beats * 1000 fits in this many bits
    localparam int PRODUCT_W     = BEATS_W + MS_CONST_W;

    localparam int SONG_DEPTH_DEF         = 256;
    localparam int BEAT_FRACTION_BITS_DEF = 4;

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(1);
    localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(30);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMPO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [BEATS_W-1:0] beats;
    } song_entry_t;

    localparam int ENTRY_W = PITCH_W + BEATS_W;

endpackage

`default_nettype wire

[hdl/mts_ram.sv]
// ----------------------------------------------------------------------------
// mts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/mts_div.sv]
// ----------------------------------------------------------------------------
// mts_div: iterative restoring divider
// One quotient bit per cycle; quotient holds after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_div #(
    parameter int DIVIDEND_W = 18,
    parameter int DIVISOR_W  = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  last,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = !diff[DIVISOR_W];
    assign last    = busy_reg && (cnt_reg == CNT_W'(DIVIDEND_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hdl/melody_tone_sequencer_core.sv]
// ----------------------------------------------------------------------------
// melody_tone_sequencer_core: looping song player driven by millisecond ticks
// Note table in RAM, note length from a single iterative divider.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A load beat goes from ST_IDLE straight to
// ST_FIN. A tick passes through ST_READ, where the table entry is taken and
// the divider is started, then ST_DIV, where the restoring divider computes
// floor(beats*1000 / (tempo << frac bits)) one quotient bit per cycle, then
// ST_FIN, which settles the result into the output register once it is free.
// A finished result waits in the output register while the next beat is taken
// in. Configuration writes land on the next clock and should only be issued
// while the block is idle.
`default_nettype none

module melody_tone_sequencer_core #(
    parameter int SONG_DEPTH         = mts_pkg::SONG_DEPTH_DEF,
    parameter int BEAT_FRACTION_BITS = mts_pkg::BEAT_FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [mts_pkg::INDEX_W-1:0]     entry_index,
    input  logic [mts_pkg::PITCH_W-1:0]     entry_pitch,
    input  logic [mts_pkg::BEATS_W-1:0]     entry_beats,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            tone_on,
    output logic [mts_pkg::PITCH_W-1:0]     tone_pitch,
    output logic [mts_pkg::INDEX_W-1:0]     note_index,
    output logic                            note_done
);

    import mts_pkg::*;

    localparam int ADDR_W    = $clog2(SONG_DEPTH);
    localparam int DIVISOR_W = TEMPO_W + BEAT_FRACTION_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TEMPO_W-1:0]   tempo_reg;
    logic [GAP_W-1:0]     gap_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [INDEX_W-1:0]   cur_note_reg, cur_note_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    logic                 cmd_reg, cmd_next;
    logic [PITCH_W-1:0]   pitch_reg, pitch_next;
    logic                 tone_on_reg, tone_on_next;
    logic [PITCH_W-1:0]   tone_pitch_reg, tone_pitch_next;
    logic [INDEX_W-1:0]   note_index_reg, note_index_next;
    logic                 note_done_reg, note_done_next;

    logic                 accept;
    logic                 load_in_range;
    logic                 cur_in_range;
    song_entry_t          wr_entry;
    song_entry_t          rd_entry;
    logic [ENTRY_W-1:0]   rd_data;
    logic [BEATS_W-1:0]   beats_eff;
    logic [TEMPO_W-1:0]   tempo_eff;
    logic                 div_start;
    logic                 div_last;
    logic [PRODUCT_W-1:0] dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [PRODUCT_W-1:0] dur;
    logic [PRODUCT_W-1:0] gap_ext;
    logic [PRODUCT_W-1:0] thr;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [PRODUCT_W-1:0] elapsed_ext;
    logic [COUNT_W-1:0]   count_eff;
    logic [COUNT_W-1:0]   next_note;
    logic                 slot_free;
    logic                 commit;

    assign in_ready      = (state_reg == ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign load_in_range = 32'(entry_index) < 32'(SONG_DEPTH);
    assign cur_in_range  = 32'(cur_note_reg) < 32'(SONG_DEPTH);

    assign wr_entry.pitch = entry_pitch;
    assign wr_entry.beats = entry_beats;

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SONG_DEPTH)
    ) u_song_ram (
        .clk   (clk),
        .we    (accept && (command == CMD_LOAD) && load_in_range),
        .waddr (ADDR_W'(entry_index)),
        .wdata (wr_entry),
        .raddr (ADDR_W'(cur_note_reg)),
        .rdata (rd_data)
    );

    assign rd_entry  = song_entry_t'(rd_data);
    assign beats_eff = cur_in_range ? rd_entry.beats : '0;
    assign tempo_eff = (tempo_reg == '0) ? TEMPO_W'(1) : tempo_reg;
    assign dividend  = PRODUCT_W'(beats_eff) * PRODUCT_W'(MS_PER_SECOND);
    assign divisor   = DIVISOR_W'(tempo_eff) << BEAT_FRACTION_BITS;
    assign div_start = (state_reg == ST_READ);

    mts_div #(
        .DIVIDEND_W (PRODUCT_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .last     (div_last),
        .quotient (dur)
    );

    // Threshold saturates to zero when the gap is longer than the note
    assign gap_ext     = PRODUCT_W'(gap_reg);
    assign thr         = (dur > gap_ext) ? (dur - gap_ext) : '0;
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : (elapsed_reg + 1'b1);
    assign elapsed_ext = PRODUCT_W'(elapsed_inc);
    assign count_eff   = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    assign next_note   = COUNT_W'(cur_note_reg) + 1'b1;

    assign slot_free = !out_valid_reg || out_ready;
    assign commit    = (state_reg == ST_FIN) && slot_free;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        cur_note_next   = cur_note_reg;
        elapsed_next    = elapsed_reg;
        cmd_next        = cmd_reg;
        pitch_next      = pitch_reg;
        tone_on_next    = tone_on_reg;
        tone_pitch_next = tone_pitch_reg;
        note_index_next = note_index_reg;
        note_done_next  = note_done_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    state_next = (command == CMD_LOAD) ? ST_FIN : ST_READ;
                end
            end
            ST_READ:
            begin
                pitch_next = cur_in_range ? rd_entry.pitch : '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (commit)
                begin
                    out_valid_next  = 1'b1;
                    note_index_next = cur_note_reg;
                    tone_on_next    = 1'b0;
                    tone_pitch_next = '0;
                    note_done_next  = 1'b0;
                    state_next      = ST_IDLE;
                    if (cmd_reg == CMD_TICK)
                    begin
                        if (elapsed_ext < thr)
                        begin
                            elapsed_next = elapsed_inc;
                            if (pitch_reg != '0)
                            begin
                                tone_on_next    = 1'b1;
                                tone_pitch_next = pitch_reg;
                            end
                        end
                        else if (elapsed_ext < dur)
                        begin
                            elapsed_next = elapsed_inc;
                        end
                        else
                        begin
                            // end of note: restart time, advance and wrap the index
                            note_done_next = 1'b1;
                            elapsed_next   = '0;
                            if ((next_note >= count_eff) || next_note[COUNT_W-1])
                            begin
                                cur_note_next = '0;
                            end
                            else
                            begin
                                cur_note_next = next_note[INDEX_W-1:0];
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_note_reg  <= '0;
            elapsed_reg   <= '0;
            tempo_reg     <= TEMPO_RESET;
            gap_reg       <= GAP_RESET;
            count_reg     <= COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_note_reg  <= cur_note_next;
            elapsed_reg   <= elapsed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMPO: tempo_reg <= cfg_data[TEMPO_W-1:0];
                    REG_GAP:   gap_reg   <= cfg_data[GAP_W-1:0];
                    REG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pitch_reg      <= pitch_next;
        tone_on_reg    <= tone_on_next;
        tone_pitch_reg <= tone_pitch_next;
        note_index_reg <= note_index_next;
        note_done_reg  <= note_done_next;
    end

    assign out_valid  = out_valid_reg;
    assign tone_on    = tone_on_reg;
    assign tone_pitch = tone_pitch_reg;
    assign note_index = note_index_reg;
    assign note_done  = note_done_reg;

endmodule

`default_nettype wire

[hdl/mts_checker.sv]
// ----------------------------------------------------------------------------
// mts_checker: port-level checks for the melody tone sequencer
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic                            tone_on,
    input wire logic [mts_pkg::PITCH_W-1:0]     tone_pitch,
    input wire logic [mts_pkg::INDEX_W-1:0]     note_index,
    input wire logic                            note_done
);

    // one item at a time: the block is busy right after taking a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready held high after an accepted beat");

    // a note never sounds on the tick that ends it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_done |-> !tone_on)
        else $error("tone_on set on a note_done beat");

    // pitch is shown exactly when the tone sounds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tone_on == (tone_pitch != '0)))
        else $error("tone_pitch does not match tone_on");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tone_pitch)
            && $stable(note_index) && $stable(note_done) && $stable(tone_on))
        else $error("stalled result changed");

endmodule

bind melody_tone_sequencer_core mts_checker u_mts_checker (.*);

`default_nettype wire

[tb/mts_playback_checker.sv]
// ----------------------------------------------------------------------------
// mts_playback_checker: playback predictor and result checker
// Watches the configuration port and both beat channels of the melody tone
// sequencer. It keeps its own copy of the song table, the note position and
// the registers, works out the tone result of every accepted input beat and
// compares each accepted output beat, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module mts_playback_checker
    import mts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   command,
    input  logic [INDEX_W-1:0]     entry_index,
    input  logic [PITCH_W-1:0]     entry_pitch,
    input  logic [BEATS_W-1:0]     entry_beats,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   tone_on,
    input  logic [PITCH_W-1:0]     tone_pitch,
    input  logic [INDEX_W-1:0]     note_index,
    input  logic                   note_done,
    output int                     fail_count,
    output int                     outstanding
);

    typedef struct packed {
        logic               tone_on;
        logic [PITCH_W-1:0] tone_pitch;
        logic [INDEX_W-1:0] note_index;
        logic               note_done;
    } tone_result_t;

    logic [TEMPO_W-1:0]   tempo_reg;
    logic [GAP_W-1:0]     gap_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [PITCH_W-1:0]   pitch_tbl [SONG_DEPTH_DEF];
    logic [BEATS_W-1:0]   beats_tbl [SONG_DEPTH_DEF];
    logic [INDEX_W-1:0]   current_note;
    logic [ELAPSED_W-1:0] elapsed_ms;

    tone_result_t expected_tones [$];
    int           errors;

    // floor(beats * 1000 / (tempo << frac bits)), tempo 0 counts as 1
    function automatic int unsigned note_ms(logic [BEATS_W-1:0] raw_beats);
        longint unsigned divisor;
        divisor = longint'(tempo_reg == '0 ? 1 : int'(tempo_reg)) << BEAT_FRACTION_BITS_DEF;
        return int'((longint'(raw_beats) * MS_PER_SECOND) / divisor);
    endfunction

    function automatic tone_result_t play_beat(logic cmd, logic [INDEX_W-1:0] wr_index,
                                               logic [PITCH_W-1:0] wr_pitch,
                                               logic [BEATS_W-1:0] wr_beats);
        tone_result_t       res;
        int unsigned        dur;
        int unsigned        thr;
        int unsigned        song_len;
        int unsigned        next_note;
        logic [PITCH_W-1:0] pitch_now;
        res = '0;
        res.note_index = current_note;
        if (cmd == CMD_LOAD)
        begin
            pitch_tbl[wr_index] = wr_pitch;
            beats_tbl[wr_index] = wr_beats;
            return res;
        end
        pitch_now = pitch_tbl[current_note];
        dur = note_ms(beats_tbl[current_note]);
        // saturate the sounding part to zero when the gap eats the whole note
        thr = (dur > gap_reg) ? dur - gap_reg : 0;
        if (elapsed_ms != '1)
            elapsed_ms = elapsed_ms + 1'b1;
        if (elapsed_ms < thr)
        begin
            if (pitch_now != '0)
            begin
                res.tone_on    = 1'b1;
                res.tone_pitch = pitch_now;
            end
        end
        else if (elapsed_ms >= dur)
        begin
            res.note_done = 1'b1;
            elapsed_ms    = '0;
            song_len      = (count_reg == '0) ? 1 : count_reg;
            next_note     = int'(current_note) + 1;
            current_note  = (next_note >= song_len || next_note > 255) ? '0 : next_note[7:0];
        end
        return res;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tone_result_t want;
        if (!rst_n)
        begin
            tempo_reg    = TEMPO_RESET;
            gap_reg      = GAP_RESET;
            count_reg    = COUNT_RESET;
            current_note = '0;
            elapsed_ms   = '0;
            errors       = 0;
            expected_tones.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMPO: tempo_reg = cfg_data[TEMPO_W-1:0];
                    REG_GAP:   gap_reg   = cfg_data[GAP_W-1:0];
                    REG_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    default:   ;
                endcase
            end
            // compare first so a result cannot match an item accepted on the same edge
            if (out_valid && out_ready)
            begin
                if (expected_tones.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected: on=%0b pitch=%0d",
                             $time, tone_on, tone_pitch);
                end
                else
                begin
                    want = expected_tones.pop_front();
                    check_field("tone_on", want.tone_on, tone_on);
                    check_field("tone_pitch", want.tone_pitch, tone_pitch);
                    check_field("note_index", want.note_index, note_index);
                    check_field("note_done", want.note_done, note_done);
                end
            end
            if (in_valid && in_ready)
                expected_tones.push_back(play_beat(command, entry_index, entry_pitch,
                                                   entry_beats));
            fail_count  <= errors;
            outstanding <= expected_tones.size();
        end
    end

endmodule

[tb/tb_melody_tone_sequencer_core.sv]
// ----------------------------------------------------------------------------
// tb_melody_tone_sequencer_core: stimulus and verdict for the tone sequencer
// Loads song entries and sends millisecond ticks through a series of register
// settings, with random idling on both channels, a long output stall and a
// drain before every register change. The checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_melody_tone_sequencer_core;
    import mts_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          MAX_NOTE_MS = 100;
    localparam int          RX_HOLD     = 400;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   command;
    logic [INDEX_W-1:0]     entry_index;
    logic [PITCH_W-1:0]     entry_pitch;
    logic [BEATS_W-1:0]     entry_beats;
    logic                   out_valid;
    logic                   out_ready;
    logic                   tone_on;
    logic [PITCH_W-1:0]     tone_pitch;
    logic [INDEX_W-1:0]     note_index;
    logic                   note_done;
    int                     fail_count;
    int                     outstanding;

    int unsigned            cycles = 0;
    bit                     no_idle = 1'b0;
    bit                     rx_hold_req = 1'b0;
    int                     rx_hold_left = 0;
    bit                     written [SONG_DEPTH_DEF];
    logic [BEATS_W-1:0]     loaded_beats [SONG_DEPTH_DEF];
    int unsigned            beats_cap;

    melody_tone_sequencer_core uut (.*);

    mts_playback_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req  = 1'b0;
                rx_hold_left = RX_HOLD;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (no_idle)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // longest beats value that keeps a note at or under MAX_NOTE_MS
    function automatic int unsigned beats_limit(logic [TEMPO_W-1:0] tempo_val);
        int unsigned t;
        int unsigned lim;
        t   = (tempo_val == '0) ? 1 : 32'(tempo_val);
        lim = ((MAX_NOTE_MS + 1) * t * (1 << BEAT_FRACTION_BITS_DEF) - 1) / MS_PER_SECOND;
        return (lim > 255) ? 255 : lim;
    endfunction

    function automatic logic [PITCH_W-1:0] rand_pitch();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PITCH_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [BEATS_W-1:0] rand_beats();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return BEATS_W'(beats_cap);
            default: return BEATS_W'($urandom_range(0, beats_cap));
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [PITCH_W-1:0] pitch, input logic [BEATS_W-1:0] beats);
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        entry_pitch <= pitch;
        entry_beats <= beats;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            written[idx]      = 1'b1;
            loaded_beats[idx] = beats;
        end
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx);
        send_item(CMD_LOAD, idx, rand_pitch(), rand_beats());
    endtask

    // drop valid and hold until every result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] tempo_val,
                                 input logic [CFG_DATA_W-1:0] gap_val,
                                 input logic [CFG_DATA_W-1:0] count_val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TEMPO;
        cfg_data  <= tempo_val;
        @(negedge clk);
        cfg_index <= REG_GAP;
        cfg_data  <= gap_val;
        @(negedge clk);
        cfg_index <= REG_COUNT;
        cfg_data  <= count_val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        beats_cap = beats_limit(tempo_val[TEMPO_W-1:0]);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] tempo_val,
                             input logic [CFG_DATA_W-1:0] gap_val,
                             input logic [CFG_DATA_W-1:0] count_val,
                             input int n_items, input bit hold_rx);
        int song_len;
        drain();
        set_registers(tempo_val, gap_val, count_val);
        song_len = (count_val[COUNT_W-1:0] == '0) ? 1 : count_val[COUNT_W-1:0];
        if (song_len > SONG_DEPTH_DEF)
            song_len = SONG_DEPTH_DEF;
        // fill the song and shorten entries that would play too long at this tempo
        for (int i = 0; i < SONG_DEPTH_DEF; i++)
        begin
            if ((i < song_len && !written[i]) || (written[i] && loaded_beats[i] > beats_cap))
                send_load(i[INDEX_W-1:0]);
        end
        rx_hold_req = hold_rx;
        repeat (n_items)
        begin
            if ($urandom_range(0, 99) < 15)
                send_load(INDEX_W'($urandom_range(0, 255)));
            else
                send_item(CMD_TICK, INDEX_W'($urandom_range(0, 255)),
                          PITCH_W'($urandom_range(0, 65535)),
                          BEATS_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        command     = CMD_TICK;
        entry_index = '0;
        entry_pitch = '0;
        entry_beats = '0;
        beats_cap   = beats_limit(TEMPO_RESET);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: a loud note, a rest, a zero-length note, table extremes
        send_item(CMD_LOAD, 8'd0, 16'hFFFF, 8'd16);
        drain();
        set_registers(16'd250, 16'd2, 16'd3);
        send_item(CMD_LOAD, 8'd1, 16'h0000, 8'd12);
        send_item(CMD_LOAD, 8'd2, 16'h0001, 8'd0);
        send_item(CMD_LOAD, 8'd255, 16'hAAAA, 8'hFF);
        send_item(CMD_TICK, 8'hFF, 16'hFFFF, 8'hFF);
        repeat (7)
            send_item(CMD_TICK, 8'd0, 16'd0, 8'd0);
        send_item(CMD_LOAD, 8'h55, 16'h5555, 8'h55);
        repeat (4)
            send_item(CMD_TICK, 8'h00, 16'h0000, 8'h00);

        run_phase(16'd1000, 16'd0, 16'd8, 200, 1'b1);
        run_phase(16'hFFFF, 16'd1023, 16'd0, 100, 1'b0);
        run_phase(16'd0, 16'd30, 16'd2, 200, 1'b0);
        run_phase(16'd1, 16'd1023, 16'd2, 80, 1'b0);
        run_phase(16'd300, 16'd5, 16'd256, 120, 1'b0);
        // every note has zero length here, so the index runs past 255 and wraps
        run_phase(16'hFFFF, 16'd0, 16'd511, 300, 1'b0);
        no_idle = 1'b1;
        run_phase(16'd2000, 16'd1, 16'd3, 200, 1'b0);
        no_idle = 1'b0;
        repeat (3)
            run_phase(CFG_DATA_W'($urandom_range(100, 4000)),
                      CFG_DATA_W'($urandom_range(0, 20)),
                      CFG_DATA_W'($urandom_range(1, 16)), 150, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hdl/mts_pkg.sv
hdl/mts_ram.sv
hdl/mts_div.sv
hdl/melody_tone_sequencer_core.sv
hdl/mts_checker.sv
tb/mts_playback_checker.sv
tb/tb_melody_tone_sequencer_core.sv
